/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, operation and status codes, and default capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Default number of entries the queue can hold.
  localparam int unsigned SPQ_CAPACITY = 16;

  // Width of the payload and priority fields.
  localparam int unsigned SPQ_WORD_W = 32;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // Status codes returned with each result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored entry of the chain.
  typedef struct packed {
    logic                         vld;
    logic signed [SPQ_WORD_W-1:0] data;
    logic signed [SPQ_WORD_W-1:0] prio;
  } entry_t;

  // Commands broadcast to every cell in the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage : spq_pkg

`default_nettype wire

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares it against the incoming priority, and takes its
// next value from itself, the left or right neighbor, or the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire spq_pkg::cell_ctl_t                           ctl,
  input  wire logic signed [spq_pkg::SPQ_WORD_W-1:0]        new_data,
  input  wire logic signed [spq_pkg::SPQ_WORD_W-1:0]        new_prio,
  input  wire spq_pkg::entry_t                              left_ent,
  input  wire logic                                         left_gt,
  input  wire spq_pkg::entry_t                              right_ent,
  output spq_pkg::entry_t                                   ent,
  output logic                                              gt
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // An empty slot counts as greater, so a new entry lands in the first
  // free slot when every stored priority is lower or equal.
  assign gt  = !ent_r.vld || (ent_r.prio > new_prio);
  assign ent = ent_r;

  // Insert shifts the tail right; removal shifts everything left.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.deq) begin
      ent_nxt = right_ent;
    end else if (ctl.enq && gt) begin
      if (left_gt) begin
        ent_nxt = left_ent;
      end else begin
        ent_nxt.vld  = 1'b1;
        ent_nxt.data = new_data;
        ent_nxt.prio = new_prio;
      end
    end
  end

  // Valid flag is control state and is cleared by reset; the payload needs
  // no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.data <= ent_nxt.data;
    ent_r.prio <= ent_nxt.prio;
  end

endmodule : spq_cell

`default_nettype wire

/* sv/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue: min-first priority queue built as a chain of cells
// Enqueue, dequeue and peek on a sorted row of (data, priority) entries.
// ----------------------------------------------------------------------------
// The queue accepts one request per clock cycle and returns its result in the
// next cycle from an output register; requests keep flowing as long as the
// result is taken. Each of the CAPACITY cells holds one entry and compares
// its priority against the incoming one in parallel, so an enqueue or a
// dequeue updates every cell at once, whatever the fill level. The lowest
// priority sits in cell 0; equal priorities leave in arrival order. A full
// queue rejects an enqueue with status full, and dequeue or peek on an empty
// queue returns status empty. Whenever no entry is returned, data and
// priority read as -1. After reset the queue is empty and ready at once.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            in_op,
  input  wire logic signed [spq_pkg::SPQ_WORD_W-1:0] in_item_data,
  input  wire logic signed [spq_pkg::SPQ_WORD_W-1:0] in_item_priority,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [1:0]                                 out_status,
  output logic signed [spq_pkg::SPQ_WORD_W-1:0]      out_front_data,
  output logic signed [spq_pkg::SPQ_WORD_W-1:0]      out_front_priority
);
  import spq_pkg::*;

  op_t       op;
  logic      accept;
  logic      is_full;
  logic      is_empty;
  cell_ctl_t ctl;

  entry_t    cell_ent [CAPACITY];
  logic      cell_gt  [CAPACITY];

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  status_t                      out_status_r;
  status_t                      out_status_nxt;
  logic signed [SPQ_WORD_W-1:0] out_data_r;
  logic signed [SPQ_WORD_W-1:0] out_data_nxt;
  logic signed [SPQ_WORD_W-1:0] out_prio_r;
  logic signed [SPQ_WORD_W-1:0] out_prio_nxt;

  // Handshake: take a new request whenever the result slot frees up.
  assign op       = op_t'(in_op);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = cell_ent[CAPACITY-1].vld;
  assign is_empty = !cell_ent[0].vld;

  // Commands for the chain, gated by fill level.
  assign ctl.enq = accept && (op == OP_ENQ) && !is_full;
  assign ctl.deq = accept && (op == OP_DEQ) && !is_empty;

  // Chain of cells; cell 0 holds the front entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    logic   left_gt;
    entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_ent = cell_ent[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_data  (in_item_data),
      .new_prio  (in_item_priority),
      .left_ent  (left_ent),
      .left_gt   (left_gt),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .gt        (cell_gt[i])
    );
  end

  // Result for the accepted request.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_prio_nxt   = out_prio_r;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_data_nxt   = '1;
      out_prio_nxt   = '1;
      unique case (op)
        OP_ENQ: begin
          if (is_full) begin
            out_status_nxt = ST_FULL;
          end
        end
        OP_DEQ, OP_PEEK: begin
          if (is_empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_data_nxt = cell_ent[0].data;
            out_prio_nxt = cell_ent[0].prio;
          end
        end
        default: begin
          out_status_nxt = ST_OK;
        end
      endcase
    end
  end

  // Output valid is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_front_data     = out_data_r;
  assign out_front_priority = out_prio_r;

endmodule : sorted_priority_queue

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted priority queue
// Drives enqueue, dequeue, peek and no-op requests with bursty pacing and a
// stalling receiver; checks each result against a software sorted queue that
// runs alongside the block, or against a directed row's fixed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import spq_pkg::*;

  localparam int unsigned CAP        = SPQ_CAPACITY;
  localparam int unsigned DIR_N      = 25;
  localparam int unsigned RAND_N     = 750;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam logic [31:0] MINV       = 32'h8000_0000;
  localparam logic [31:0] MAXV       = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG1       = 32'hFFFF_FFFF;

  // Expected contents of one result.
  typedef struct packed {
    status_t     st;
    logic [31:0] fd;
    logic [31:0] fp;
  } result_t;

  // One row of the directed table; exp is used only when fixed is set.
  typedef struct packed {
    op_t         op;
    logic [31:0] data;
    logic [31:0] prio;
    logic        fixed;
    result_t     exp;
  } stim_row_t;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // Directed requests: empty queue, no-op, extremes, ties, filling up to a
  // rejected enqueue, then dequeuing from the front.
  stim_row_t dir_tbl [DIR_N] = '{
    '{OP_DEQ,  32'h0,         32'h0,         1'b1, '{ST_EMPTY, NEG1, NEG1}},
    '{OP_PEEK, 32'h0,         32'h0,         1'b1, '{ST_EMPTY, NEG1, NEG1}},
    '{OP_NOP,  NEG1,          NEG1,          1'b1, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  MAXV,          MAXV,          1'b1, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  MINV,          MINV,          1'b1, '{ST_OK, NEG1, NEG1}},
    '{OP_PEEK, 32'h0,         32'h0,         1'b1, '{ST_OK, MINV, MINV}},
    '{OP_ENQ,  32'h0000_0000, 32'h0,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h0000_0001, 32'h0,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  NEG1,          NEG1,          1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0001, MAXV,          1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0002, MINV,          1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0003, 32'd5,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0004, 32'hFFFF_FFFB, 1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0005, 32'd3,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0006, 32'd3,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0007, 32'hFFFF_FF9C, 1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0008, 32'd1000,      1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_0009, 32'd2,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'h1111_000A, 32'h0,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'hA5A5_5A5A, 32'h4000_0000, 1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_ENQ,  32'hDEAD_0000, 32'h0,         1'b1, '{ST_FULL, NEG1, NEG1}},
    '{OP_DEQ,  32'h0,         32'h0,         1'b1, '{ST_OK, MINV, MINV}},
    '{OP_DEQ,  32'h0,         32'h0,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_PEEK, 32'h0,         32'h0,         1'b0, '{ST_OK, NEG1, NEG1}},
    '{OP_NOP,  32'h0,         32'h0,         1'b1, '{ST_OK, NEG1, NEG1}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_op = OP_NOP;
  logic signed [31:0]  in_item_data = '0;
  logic signed [31:0]  in_item_priority = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic signed [31:0]  out_front_data;
  logic signed [31:0]  out_front_priority;

  // Shadow copy of the sorted queue.
  logic signed [31:0]  sq_data [CAP];
  logic signed [31:0]  sq_prio [CAP];
  int unsigned         sq_count = 0;

  result_t             pending_q[$];
  logic                row_fixed = 1'b0;
  result_t             row_exp = '0;
  int unsigned         errors = 0;
  int unsigned         cycles = 0;
  int unsigned         burst_left = 0;
  int unsigned         n_enq_ok = 0;
  int unsigned         n_full = 0;
  int unsigned         n_front = 0;
  int unsigned         n_empty = 0;
  int unsigned         peak_count = 0;
  rx_mode_t            rx_mode = RX_STREAM;
  int unsigned         rx_left = 0;

  sorted_priority_queue #(.CAPACITY(CAP)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_item_data       (in_item_data),
    .in_item_priority   (in_item_priority),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_front_data     (out_front_data),
    .out_front_priority (out_front_priority)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow queue and return the result it yields.
  function automatic result_t queue_apply(op_t op, logic signed [31:0] d,
                                          logic signed [31:0] p);
    result_t     r;
    int unsigned i;
    r = '{ST_OK, NEG1, NEG1};
    case (op)
      OP_ENQ: begin
        if (sq_count >= CAP) begin
          r.st = ST_FULL;
        end else begin
          // Shift strictly greater priorities back so ties keep arrival order.
          i = sq_count;
          while (i > 0 && sq_prio[i-1] > p) begin
            sq_data[i] = sq_data[i-1];
            sq_prio[i] = sq_prio[i-1];
            i--;
          end
          sq_data[i] = d;
          sq_prio[i] = p;
          sq_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (sq_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.fd = sq_data[0];
          r.fp = sq_prio[0];
          if (op == OP_DEQ) begin
            for (i = 1; i < sq_count; i++) begin
              sq_data[i-1] = sq_data[i];
              sq_prio[i-1] = sq_prio[i];
            end
            sq_count--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Both handshakes are judged at the falling edge, where every input and
  // output is settled for the coming rising edge.
  always @(negedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n && in_valid && in_ready) begin
      got = queue_apply(op_t'(in_op), in_item_data, in_item_priority);
      if (row_fixed) got = row_exp;
      pending_q.push_back(got);
      if (op_t'(in_op) == OP_ENQ && got.st == ST_OK) n_enq_ok++;
      if (got.st == ST_FULL) n_full++;
      if (got.st == ST_EMPTY) n_empty++;
      if (op_t'(in_op) != OP_ENQ && op_t'(in_op) != OP_NOP && got.st == ST_OK) n_front++;
      if (sq_count > peak_count) peak_count = sq_count;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding: status %0d data %h priority %h",
               out_status, out_front_data, out_front_priority);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_status);
          errors++;
        end
        if (out_front_data !== want.fd) begin
          $error("front_data: expected %h, got %h", want.fd, out_front_data);
          errors++;
        end
        if (out_front_priority !== want.fp) begin
          $error("front_priority: expected %h, got %h", want.fp, out_front_priority);
          errors++;
        end
      end
    end
  end

  // Receiver stalls follow a mode that is redrawn at random whenever its countdown runs out.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM:   out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= (rx_left[3:0] < 3);
    endcase
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one request, with a random gap first when a burst has run out,
  // and return at the edge that accepts it.
  task automatic send_req(input op_t op, input logic [31:0] d, input logic [31:0] p,
                          input logic fixed, input result_t exp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    row_fixed        <= fixed;
    row_exp          <= exp;
    in_valid         <= 1'b1;
    in_op            <= op;
    in_item_data     <= d;
    in_item_priority <= p;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned roll;
    int unsigned enq_pct;
    mix_t        mix;
    op_t         op;
    logic [31:0] d;
    logic [31:0] p;
    mix = MIX_EVEN;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (n = 0; n < DIR_N; n++) begin
      send_req(dir_tbl[n].op, dir_tbl[n].data, dir_tbl[n].prio,
               dir_tbl[n].fixed, dir_tbl[n].exp);
    end
    drain_wait();

    // Random traffic in phases that lean toward filling or draining, so the
    // queue swings between empty and full.
    for (n = 0; n < RAND_N; n++) begin
      if (n % 40 == 0) mix = mix_t'($urandom_range(0, 2));
      if (n == RAND_N / 2) drain_wait();
      case (mix)
        MIX_FILL:  enq_pct = 80;
        MIX_DRAIN: enq_pct = 25;
        default:   enq_pct = 50;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OP_NOP;
      else if (roll < enq_pct) op = OP_ENQ;
      else if (roll < enq_pct + (100 - enq_pct) * 2 / 3) op = OP_DEQ;
      else op = OP_PEEK;
      d = $urandom;
      // Mostly a narrow key range so ties are frequent, with full-range and
      // extreme keys mixed in.
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: p = $urandom_range(0, 15) - 8;
        6, 7:             p = $urandom;
        8:                p = $urandom_range(0, 1) ? MAXV : MINV;
        default:          p = $urandom_range(0, 1) ? MAXV - $urandom_range(0, 3)
                                                   : MINV + $urandom_range(0, 3);
      endcase
      send_req(op, d, p, 1'b0, '0);
    end
    drain_wait();
    repeat (10) @(posedge clk);

    $display("Ran %0d directed and %0d random requests: %0d enqueues stored, %0d rejected full.",
             DIR_N, RAND_N, n_enq_ok, n_full);
    $display("Front entries returned: %0d, empty answers: %0d, peak fill %0d of %0d.",
             n_front, n_empty, peak_count, CAP);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
verif/tb_top.sv
